>>> rtl/core/irc_pkg.sv
// Shared types and constants for the IR carrier pulse-train player.
package irc_pkg;

  localparam int PAIRS_DEF     = 64;
  localparam int TIME_BITS_DEF = 16;

  localparam int HALF_W      = 9;
  localparam int LEN_W       = 7;
  localparam int FIELD_T_W   = 16;
  localparam int IDX_W       = 6;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  localparam logic [HALF_W-1:0] HALF_RESET = 9'd13;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd0;

  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEQ_LENGTH  = 2'd1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [IDX_W-1:0]     entry_index;
    logic [FIELD_T_W-1:0] mark_us;
    logic [FIELD_T_W-1:0] gap_us;
  } item_t;

  typedef struct packed {
    logic done_res;
    logic busy_res;
    logic led_on;
  } result_t;

endpackage

>>> rtl/core/irc_ram.sv
// Generic single write port, single read port RAM with registered read.
module irc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/irc_engine.sv
// Playback state, pair table and per-word update of the pulse-train player.
module irc_engine import irc_pkg::*; #(
  parameter int PAIRS     = PAIRS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  item_t             item,
  input  logic [HALF_W-1:0] half_cfg,
  input  logic [LEN_W-1:0]  len_cfg,
  output result_t           res
);

  localparam int AW  = $clog2(PAIRS);
  localparam int PW  = $clog2(PAIRS + 1);
  localparam int TW  = TIME_BITS;
  localparam int FW  = HALF_W + 1;
  localparam int CW  = (TW > FW) ? TW : FW;
  localparam int CPW = (PW > LEN_W) ? PW : LEN_W;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_MARK  = 3'b010,
    PH_SPACE = 3'b100
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [PW-1:0]   ptr_r, ptr_nxt;
  logic [TW-1:0]   rem_r, rem_nxt;
  logic [HALF_W-1:0] half_cnt_r, half_cnt_nxt;
  logic            level_r, level_nxt;
  logic [TW-1:0]   cur_space_r, cur_space_nxt;
  logic [TW-1:0]   head_mark_r, head_space_r;

  logic [HALF_W-1:0] half_eff;
  logic [FW-1:0]     full;
  logic [HALF_W:0]   half_inc;
  logic              half_hit;
  logic              busy;
  logic              done;
  op_t               op;

  logic [TW+FIELD_T_W-1:0] mark_ext, space_ext;
  logic [TW-1:0]           ld_mark, ld_space;
  logic [AW+IDX_W-1:0]     idx_ext;
  logic                    idx_ok;
  logic                    ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [2*TW-1:0]         ram_rdata;
  logic [TW-1:0]           rd_mark, rd_space;

  logic [PW-1:0]  ptr_inc;
  logic           stop_first, stop_next;
  logic [TW-1:0]  rem_dec;
  logic [CW-1:0]  rem_cmp, full_cmp;

  assign half_eff = (half_cfg == '0) ? HALF_W'(1) : half_cfg;
  assign full     = {half_eff, 1'b0};
  assign half_inc = {1'b0, half_cnt_r} + (HALF_W+1)'(1);
  assign half_hit = half_inc >= {1'b0, half_eff};
  assign busy     = phase_r != PH_IDLE;

  assign mark_ext  = {{TW{1'b0}}, item.mark_us};
  assign space_ext = {{TW{1'b0}}, item.gap_us};
  assign ld_mark   = mark_ext[TW-1:0];
  assign ld_space  = space_ext[TW-1:0];
  assign idx_ext   = {{AW{1'b0}}, item.entry_index};
  assign idx_ok    = 32'(item.entry_index) < PAIRS;
  assign ram_we    = fire && (item.opcode == OP_LOAD) && !busy && idx_ok;

  assign ptr_inc   = ptr_r + PW'(1);
  assign ram_raddr = ptr_inc[AW-1:0];
  assign rd_mark   = ram_rdata[TW-1:0];
  assign rd_space  = ram_rdata[2*TW-1:TW];

  assign stop_first = (len_cfg == '0) || (head_mark_r == '0);
  assign stop_next  = (CPW'(ptr_inc) >= CPW'(len_cfg)) || (32'(ptr_inc) >= PAIRS) ||
                      (rd_mark == '0);

  assign rem_dec  = (rem_r != '0) ? rem_r - TW'(1) : rem_r;
  assign rem_cmp  = CW'(rem_r);
  assign full_cmp = CW'(full);

  irc_ram #(
    .WIDTH(2 * TW),
    .DEPTH(PAIRS)
  ) u_pair_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_ext[AW-1:0]),
    .wdata({ld_space, ld_mark}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    op            = op_t'(item.opcode);
    phase_nxt     = phase_r;
    ptr_nxt       = ptr_r;
    rem_nxt       = rem_r;
    half_cnt_nxt  = half_cnt_r;
    level_nxt     = level_r;
    cur_space_nxt = cur_space_r;
    done          = 1'b0;
    if (fire) begin
      unique case (item.opcode)
        OP_START: begin
          if (!busy) begin
            ptr_nxt      = '0;
            half_cnt_nxt = '0;
            if (stop_first) begin
              phase_nxt = PH_IDLE;
              rem_nxt   = '0;
              level_nxt = 1'b0;
              done      = 1'b1;
            end else begin
              phase_nxt     = PH_MARK;
              rem_nxt       = head_mark_r;
              level_nxt     = 1'b1;
              cur_space_nxt = head_space_r;
            end
          end
        end
        OP_TICK: begin
          if (phase_r == PH_MARK) begin
            if (!half_hit) begin
              half_cnt_nxt = half_inc[HALF_W-1:0];
            end else begin
              half_cnt_nxt = '0;
              if (level_r) begin
                level_nxt = 1'b0;
              end else if (rem_cmp > full_cmp) begin
                rem_nxt   = TW'(rem_cmp - full_cmp);
                level_nxt = 1'b1;
              end else if (cur_space_r != '0) begin
                phase_nxt = PH_SPACE;
                rem_nxt   = cur_space_r;
              end else begin
                phase_nxt = PH_IDLE;
                rem_nxt   = '0;
                done      = 1'b1;
              end
            end
          end else if (phase_r == PH_SPACE) begin
            rem_nxt = rem_dec;
            if (rem_dec == '0) begin
              ptr_nxt      = ptr_inc;
              half_cnt_nxt = '0;
              if (stop_next) begin
                phase_nxt = PH_IDLE;
                rem_nxt   = '0;
                level_nxt = 1'b0;
                done      = 1'b1;
              end else begin
                phase_nxt     = PH_MARK;
                rem_nxt       = rd_mark;
                level_nxt     = 1'b1;
                cur_space_nxt = rd_space;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.led_on   = (op == OP_START && !busy) ? level_nxt : level_r;
    res.busy_res = phase_nxt != PH_IDLE;
    res.done_res = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      ptr_r      <= '0;
      rem_r      <= '0;
      half_cnt_r <= '0;
      level_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      ptr_r      <= ptr_nxt;
      rem_r      <= rem_nxt;
      half_cnt_r <= half_cnt_nxt;
      level_r    <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_space_r <= cur_space_nxt;
    if (ram_we && item.entry_index == '0) begin
      head_mark_r  <= ld_mark;
      head_space_r <= ld_space;
    end
  end

  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_SPACE) |-> !level_r)
    else $error("LED lit outside a mark");

  a_mark_time: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MARK) |-> (rem_r != '0 && half_cnt_r < half_eff))
    else $error("mark counters out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.done_res) |=> (phase_r == PH_IDLE))
    else $error("done without returning to idle");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (phase_r == PH_IDLE))
    else $error("table written during playback");

endmodule

>>> rtl/core/ir_carrier_pulse_train_player_core.sv
// Top level of the IR carrier pulse-train player: stream ports, config and skid stages.
//
//  channel  | ports          | word contents
//  ---------+----------------+---------------------------------------------
//  input    | in_t*          | tuser: opcode; tdata: index, mark, space
//  result   | out_t*         | tdata: led_on, busy_res, done_res
//  config   | cfg_*          | 0 carrier half period, 1 sequence length
//
//  One word per cycle sustained while out_tready stays high; each word passes
//  through the input register and then the result register.
//  Every word is updated against the playback state by combinational engine logic.
//  Reset returns playback to idle with the LED off; the pair table is not cleared.
//  While a result waits on out_tready the input register takes one more word,
//  then in_tready stays low until the result leaves.
module ir_carrier_pulse_train_player_core import irc_pkg::*; #(
  parameter int PAIRS     = PAIRS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_index[5:0], mark_us[21:6], gap_us[37:22]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // opcode[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // led_on[0], busy_res[1], done_res[2]
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic              in_valid_r, in_valid_nxt;
  item_t             item_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           res, res_r;
  logic              advance;
  logic [HALF_W-1:0] half_r;
  logic [LEN_W-1:0]  len_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      half_r      <= HALF_RESET;
      len_r       <= LEN_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_HALF_PERIOD: half_r <= cfg_wdata[HALF_W-1:0];
          CFG_SEQ_LENGTH:  len_r  <= cfg_wdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.opcode      <= in_tuser[1:0];
      item_r.entry_index <= in_tdata[5:0];
      item_r.mark_us     <= in_tdata[21:6];
      item_r.gap_us      <= in_tdata[37:22];
    end
    if (advance) begin
      res_r <= res;
    end
  end

  irc_engine #(
    .PAIRS    (PAIRS),
    .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (item_r),
    .half_cfg(half_r),
    .len_cfg (len_r),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-3){1'b0}}, res_r.done_res, res_r.busy_res, res_r.led_on};

endmodule
